>>> design/fsmf_pkg.sv
// shared types and constants for the first substring match finder
// no dependencies
`default_nettype none

package fsmf_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;
   localparam int TEXT_MAX_DEFAULT    = 65536;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_START  = 2'd2,
      CMD_TEXT   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  data_byte;
      logic [15:0] start_position;
      logic        text_last;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] match_position;
   } rsp_type;

   typedef struct packed {
      logic text_shift;
      logic pat_shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> design/fsmf_cell.sv
// one compare cell: a text window byte and a pattern byte, both shifting on
// depends on fsmf_pkg
`default_nettype none

module fsmf_cell (
   input  wire                    clock,
   input  fsmf_pkg::cell_ctrl_type ctrl,
   input  wire                    in_use,
   input  wire  [7:0]             text_in,
   input  wire  [7:0]             pat_in,
   output logic [7:0]             text_out,
   output logic [7:0]             pat_out,
   output logic                   hit
);
   import fsmf_pkg::*;

   logic [7:0] text_ff;
   logic [7:0] pat_ff;

   always_ff @(posedge clock) begin
      if (ctrl.text_shift) begin
         text_ff <= text_in;
      end
      if (ctrl.pat_shift) begin
         pat_ff <= pat_in;
      end
   end

   // compare against the byte entering this cell
   assign hit      = !in_use || (text_in == pat_ff);
   assign text_out = text_ff;
   assign pat_out  = pat_ff;

endmodule

`default_nettype wire

>>> design/fsmf_chain.sv
// row of compare cells holding the text window and the reversed pattern
// depends on fsmf_pkg and fsmf_cell
`default_nettype none

module fsmf_chain #(
   parameter int PATTERN_MAX = fsmf_pkg::PATTERN_MAX_DEFAULT,
   parameter int LW          = $clog2(PATTERN_MAX + 1)
) (
   input  wire                     clock,
   input  fsmf_pkg::cell_ctrl_type ctrl,
   input  wire  [7:0]              text_byte,
   input  wire  [7:0]              pat_byte,
   input  wire  [LW-1:0]           pat_len,
   output logic                    all_hit
);
   import fsmf_pkg::*;

   logic [7:0]             text_link [0:PATTERN_MAX-1];
   logic [7:0]             pat_link  [0:PATTERN_MAX-1];
   logic [7:0]             text_q    [0:PATTERN_MAX-1];
   logic [7:0]             pat_q     [0:PATTERN_MAX-1];
   logic [PATTERN_MAX-1:0] hit_vec;

   assign text_link[0] = text_byte;
   assign pat_link[0]  = pat_byte;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      if (j > 0) begin : g_link
         assign text_link[j] = text_q[j-1];
         assign pat_link[j]  = pat_q[j-1];
      end
      fsmf_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .in_use   (LW'(j) < pat_len),
         .text_in  (text_link[j]),
         .pat_in   (pat_link[j]),
         .text_out (text_q[j]),
         .pat_out  (pat_q[j]),
         .hit      (hit_vec[j])
      );
   end

   assign all_hit = &hit_vec;

endmodule

`default_nettype wire

>>> design/first_substring_match_finder_top.sv
// first substring match finder: command decode, search control, result register
// depends on fsmf_pkg, fsmf_chain and fsmf_cell
`default_nettype none

// Streams text one transaction per cycle and reports the first index at or after
// the search start where the stored pattern occurs. A new transaction is taken each
// cycle while the result register is free or being drained. The pattern and the
// last PATTERN_MAX text bytes sit in a row of PATTERN_MAX cells, and all cells
// compare in the cycle the text byte arrives, so a result is registered in the
// cycle after the transaction that completes the match, the final text byte, or
// a start with an empty pattern.

module first_substring_match_finder_top #(
   parameter int PATTERN_MAX = fsmf_pkg::PATTERN_MAX_DEFAULT,
   parameter int TEXT_MAX    = fsmf_pkg::TEXT_MAX_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  fsmf_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output fsmf_pkg::rsp_type rsp_payload
);
   import fsmf_pkg::*;

   localparam int LW = $clog2(PATTERN_MAX + 1);
   localparam int IW = $clog2(TEXT_MAX + 1);
   localparam int PW = (IW > 16) ? IW : 16;

   logic [LW-1:0] len_ff, len_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [15:0]   start_ff, start_in;
   logic          active_ff, active_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          req_fire;
   logic          result;
   logic          all_hit;
   cell_ctrl_type ctrl;
   logic [IW-1:0] idx_next;
   logic [PW-1:0] idx_ext;
   logic [PW-1:0] len_ext;
   logic [PW-1:0] diff;
   logic          window_match;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign idx_next = idx_ff + IW'(1);
   assign idx_ext  = PW'(idx_next);
   assign len_ext  = PW'(len_ff);
   assign diff     = idx_ext - len_ext;

   assign window_match = all_hit && (len_ff != '0) && (idx_ext >= len_ext)
                         && (diff >= PW'(start_ff));

   fsmf_chain #(
      .PATTERN_MAX (PATTERN_MAX),
      .LW          (LW)
   ) u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .text_byte (req_payload.data_byte),
      .pat_byte  (req_payload.data_byte),
      .pat_len   (len_ff),
      .all_hit   (all_hit)
   );

   always_comb begin
      len_in          = len_ff;
      idx_in          = idx_ff;
      start_in        = start_ff;
      active_in       = active_ff;
      ctrl.text_shift = 1'b0;
      ctrl.pat_shift  = 1'b0;
      result          = 1'b0;
      rsp_in          = rsp_ff;
      if (req_fire) begin
         unique case (req_payload.command)
            CMD_CLEAR: begin
               len_in = '0;
            end
            CMD_APPEND: begin
               if (len_ff < LW'(PATTERN_MAX)) begin
                  ctrl.pat_shift = 1'b1;
                  len_in         = len_ff + LW'(1);
               end
            end
            CMD_START: begin
               start_in = req_payload.start_position;
               idx_in   = '0;
               if (len_ff == '0) begin
                  active_in             = 1'b0;
                  result                = 1'b1;
                  rsp_in.found          = 1'b1;
                  rsp_in.match_position = req_payload.start_position;
               end else begin
                  active_in = 1'b1;
               end
            end
            CMD_TEXT: begin
               if (active_ff) begin
                  if (idx_ff < IW'(TEXT_MAX)) begin
                     ctrl.text_shift = 1'b1;
                     idx_in          = idx_next;
                  end
                  if ((idx_ff < IW'(TEXT_MAX)) && window_match) begin
                     active_in             = 1'b0;
                     result                = 1'b1;
                     rsp_in.found          = 1'b1;
                     rsp_in.match_position = diff[15:0];
                  end else if (req_payload.text_last) begin
                     active_in             = 1'b0;
                     result                = 1'b1;
                     rsp_in.found          = 1'b0;
                     rsp_in.match_position = '0;
                  end
               end
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
      if (result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         idx_ff       <= '0;
         start_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         start_ff     <= start_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(PATTERN_MAX))
      else $error("pattern length beyond capacity");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IW'(TEXT_MAX))
      else $error("text index beyond range");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.match_position == 16'd0))
      else $error("not-found result carries a position");

   a_result_ends_search: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_payload.command == CMD_TEXT) && result) |=> !active_ff)
      else $error("search still active after its result");

endmodule

`default_nettype wire

>>> bench/tb_first_substring_match_finder_top.sv
`timescale 1ns / 100ps
// self-checking bench for first_substring_match_finder_top: a directed table, then random
// pattern, search and text sequences checked by a search model
// depends on fsmf_pkg and the first_substring_match_finder_top design files

module tb_first_substring_match_finder_top;
   import fsmf_pkg::*;

   localparam int PMAX         = PATTERN_MAX_DEFAULT;
   localparam int TMAX         = TEXT_MAX_DEFAULT;
   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      req_type req;
      bit      typed;
      bit      has_rsp;
      rsp_type rsp;
   } stim_row_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // search model state
   logic [7:0]  pat_mem [PMAX];
   logic [7:0]  txt_win [PMAX];
   int unsigned pat_count   = 0;
   int unsigned txt_count   = 0;
   int unsigned search_from = 0;
   bit          search_on   = 1'b0;

   rsp_type      expected_matches [$];
   stim_row_type directed_rows [$];
   logic [7:0]   plan_pat [$];
   logic [7:0]   alphabet [4];

   int fail_count   = 0;
   int items_sent   = 0;
   int results_seen = 0;
   int cycle_count  = 0;
   int snd_idle     = 0;
   int rcv_idle     = 0;
   int hold_left    = 0;
   bit hold_request = 1'b0;

   first_substring_match_finder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic bit predict_match(input req_type r, output rsp_type res);
      int k;
      bit hit;
      res = '0;
      case (r.command)
         CMD_CLEAR: begin
            pat_count = 0;
            return 1'b0;
         end
         CMD_APPEND: begin
            if (pat_count < PMAX) begin
               pat_mem[pat_count] = r.data_byte;
               pat_count++;
            end
            return 1'b0;
         end
         CMD_START: begin
            search_from = r.start_position;
            txt_count   = 0;
            if (pat_count == 0) begin
               search_on          = 1'b0;
               res.found          = 1'b1;
               res.match_position = r.start_position;
               return 1'b1;
            end
            search_on = 1'b1;
            return 1'b0;
         end
         default: begin
            if (!search_on) return 1'b0;
            if (txt_count < TMAX) begin
               for (k = PMAX - 1; k > 0; k--) txt_win[k] = txt_win[k - 1];
               txt_win[0] = r.data_byte;
               txt_count++;
               hit = pat_count != 0 && txt_count >= pat_count &&
                     txt_count - pat_count >= search_from;
               for (k = 0; k < pat_count; k++)
                  if (txt_win[pat_count - 1 - k] != pat_mem[k]) hit = 1'b0;
               if (hit) begin
                  search_on          = 1'b0;
                  res.found          = 1'b1;
                  res.match_position = 16'(txt_count - pat_count);
                  return 1'b1;
               end
            end
            if (r.text_last) begin
               search_on = 1'b0;
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   task automatic drive_req(input req_type r, input bit typed, input bit typed_has,
                            input rsp_type typed_rsp);
      rsp_type res;
      bit      has;
      while ($urandom_range(0, 99) < snd_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (!(r.command == CMD_TEXT && !search_on)) items_sent++;
      has = predict_match(r, res);
      if (typed) begin
         has = typed_has;
         res = typed_rsp;
      end
      if (has) expected_matches.push_back(res);
   endtask

   task automatic send(input cmd_type c, input logic [7:0] b, input logic [15:0] s,
                       input logic l);
      req_type r;
      r.command        = c;
      r.data_byte      = b;
      r.start_position = s;
      r.text_last      = l;
      drive_req(r, 1'b0, 1'b0, '0);
   endtask

   task automatic add_row(input cmd_type c, input logic [7:0] b, input logic [15:0] s,
                          input logic l, input bit typed, input bit has, input logic f,
                          input logic [15:0] p);
      stim_row_type row;
      row.req.command        = c;
      row.req.data_byte      = b;
      row.req.start_position = s;
      row.req.text_last      = l;
      row.typed              = typed;
      row.has_rsp            = has;
      row.rsp.found          = f;
      row.rsp.match_position = p;
      directed_rows.push_back(row);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_matches.size() != 0);
   endtask

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 99) < 10) return 8'($urandom);
      return alphabet[$urandom_range(0, 1)];
   endfunction

   task automatic run_sequence();
      int         n;
      int         len;
      int         at;
      int         k;
      int         pick;
      logic [7:0] b;
      logic [15:0] s;
      logic [7:0] txt [$];
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         send(cmd_type'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 1'($urandom));
         return;
      end
      if ($urandom_range(0, 99) < 20)
         for (k = 0; k < 4; k++) alphabet[k] = 8'($urandom);
      if ($urandom_range(0, 99) < 70) begin
         send(CMD_CLEAR, 8'($urandom), 16'($urandom), 1'($urandom));
         plan_pat.delete();
         pick = $urandom_range(0, 99);
         len  = pick < 85 ? $urandom_range(0, 6) :
                pick < 95 ? $urandom_range(7, 20) : $urandom_range(30, 35);
         for (k = 0; k < len; k++) begin
            b = pick_byte();
            send(CMD_APPEND, b, 16'($urandom), 1'($urandom));
            plan_pat.push_back(b);
         end
      end
      pick = $urandom_range(0, 99);
      s    = pick < 70 ? 16'($urandom_range(0, 8)) :
             pick < 90 ? 16'($urandom_range(0, 40)) : 16'($urandom);
      send(CMD_START, 8'($urandom), s, 1'($urandom));
      n = $urandom_range(1, 48);
      for (k = 0; k < n; k++) txt.push_back(pick_byte());
      if (plan_pat.size() > 0 && $urandom_range(0, 99) < 60) begin
         at = $urandom_range(0, n - 1);
         for (k = 0; k < plan_pat.size(); k++) txt.insert(at + k, plan_pat[k]);
      end
      for (k = 0; k < txt.size(); k++) begin
         if ($urandom_range(0, 99) < 3)
            send(cmd_type'($urandom_range(0, 1)), pick_byte(), 16'($urandom), 1'($urandom));
         send(CMD_TEXT, txt[k], 16'($urandom),
              (k == txt.size() - 1) ? ($urandom_range(0, 99) < 90) : ($urandom_range(0, 99) < 2));
      end
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_matches.size() == 0) begin
               $error("unexpected transaction: found %0d match_position %0d",
                      rsp_payload.found, rsp_payload.match_position);
               fail_count++;
            end else begin
               want = expected_matches.pop_front();
               results_seen++;
               if (rsp_payload.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_payload.found);
                  fail_count++;
               end
               if (rsp_payload.match_position !== want.match_position) begin
                  $error("match_position: expected %0d, actual %0d",
                         want.match_position, rsp_payload.match_position);
                  fail_count++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle);
         end
      end
   end

   initial begin
      int k;
      int p;
      int base;
      for (k = 0; k < PMAX; k++) begin
         pat_mem[k] = 8'h00;
         txt_win[k] = 8'h00;
      end
      alphabet[0] = 8'h00;
      alphabet[1] = 8'hFF;
      alphabet[2] = 8'h5A;
      alphabet[3] = 8'hA5;

      // empty pattern, idle text, simple and offset matches, start past the text
      add_row(CMD_START,  8'h00, 16'd0,     1'b0, 1, 1, 1'b1, 16'd0);
      add_row(CMD_START,  8'hFF, 16'hFFFF,  1'b1, 1, 1, 1'b1, 16'hFFFF);
      add_row(CMD_TEXT,   8'hFF, 16'd0,     1'b1, 1, 0, 1'b0, 16'd0);
      add_row(CMD_APPEND, 8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_APPEND, 8'hFF, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_START,  8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'hFF, 16'd0,     1'b0, 1, 1, 1'b1, 16'd0);
      add_row(CMD_START,  8'h00, 16'd1,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'hFF, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'hFF, 16'd0,     1'b1, 0, 0, 1'b0, 16'd0);
      add_row(CMD_START,  8'h00, 16'hFFFF,  1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'hFF, 16'd0,     1'b1, 1, 1, 1'b0, 16'd0);
      // pattern edits and restart while a search runs
      add_row(CMD_START,  8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_CLEAR,  8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_APPEND, 8'h5A, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'h5A, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_START,  8'h00, 16'd4,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'h5A, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_START,  8'h00, 16'd0,     1'b0, 0, 0, 1'b0, 16'd0);
      add_row(CMD_TEXT,   8'h5A, 16'd0,     1'b1, 0, 0, 1'b0, 16'd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      snd_idle = 32;
      rcv_idle = 75;
      foreach (directed_rows[k])
         drive_req(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].has_rsp,
                   directed_rows[k].rsp);
      wait_drained();

      for (p = 0; p < 3; p++) begin
         snd_idle = (p == 0) ? 32 : (p == 1) ? 75 : 0;
         rcv_idle = (p == 0) ? 75 : (p == 1) ? 32 : 0;
         if (p == 2) hold_request = 1'b1;
         base = items_sent;
         while (items_sent - base < RANDOM_ITEMS / 3 + 1) run_sequence();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d transactions in, %0d results checked, empty and long patterns,",
               items_sent, results_seen);
      $display("pattern overflow, mid-search edits and restarts, under three idle mixes");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
